// ----- rtl/mvna_pkg.sv -----
// ----------------------------------------------------------------------------
// mvna_pkg: shared types and constants of the vertex normal accumulator
// Holds the beat structs of both channels, the operation codes and the store
// sizing constants used by every module of the block.
// ----------------------------------------------------------------------------
package mvna_pkg;

	localparam int unsigned VertexCountDefault = 1024;
	localparam int unsigned IndexW = 10;
	localparam int unsigned CoordW = 16;
	localparam int unsigned CompW = 20;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_ADD   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]               op;
		logic [IndexW-1:0]        index_a;
		logic [IndexW-1:0]        index_b;
		logic [IndexW-1:0]        index_c;
		logic signed [CoordW-1:0] coord_x;
		logic signed [CoordW-1:0] coord_y;
		logic signed [CoordW-1:0] coord_z;
	} in_beat_t;

	typedef struct packed {
		logic signed [CompW-1:0] normal_x;
		logic signed [CompW-1:0] normal_y;
		logic signed [CompW-1:0] normal_z;
		logic                    saturated;
	} out_beat_t;

	// Command from the sequencer to the shared divide and root unit.
	typedef struct packed {
		logic        start;
		logic        is_sqrt;
		logic [63:0] num;
		logic [31:0] den;
	} alu_cmd_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} alu_rsp_t;

endpackage

// ----- rtl/mesh_vertex_normal_accumulator.sv -----
// A load or clear is written to the store as it is accepted; a read goes through the
// read wait and accumulate wait states to out_valid, skipping both for an index beyond
// the store. An add keeps the block busy through one 32-step root and three 64-step
// divides on the shared bit-serial unit, plus three read-modify-writes; a zero-area
// face stops at the magnitude check. One item at a time; stall stays high while busy.
// Reset: arst_n clears the sequencer, the output valid flag and the winding bit.
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator: vertex normal accumulator, top level
// Joins the sequencer with its store, the shared divide and root unit and the
// output register that holds a read result until it is taken.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_accumulator #(
	parameter int unsigned VERTEX_COUNT = mvna_pkg::VertexCountDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mvna_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mvna_pkg::out_beat_t  out_data
);

	logic                rev_q;
	logic                busy;
	logic                res_valid;
	mvna_pkg::out_beat_t res_beat;
	mvna_pkg::alu_cmd_t  alu_cmd;
	mvna_pkg::alu_rsp_t  alu_rsp;
	logic                in_go;

	// The input is held off while an item is at work, while a read result is
	// on its way into the output register, and while it still sits there, so
	// that a waiting result is never overwritten.
	assign in_stall = busy || res_valid || out_valid;
	assign in_go    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) rev_q <= cfg_wdata;
			if (res_valid) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_data <= res_beat;
	end

	mvna_seq #(.VERTEX_COUNT(VERTEX_COUNT)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.rev_winding (rev_q),
		.in_go       (in_go),
		.in_beat     (in_data),
		.busy        (busy),
		.res_valid   (res_valid),
		.res_beat    (res_beat),
		.alu_cmd     (alu_cmd),
		.alu_rsp     (alu_rsp)
	);

	mvna_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.rsp    (alu_rsp)
	);

endmodule

// ----- rtl/mvna_alu.sv -----
// ----------------------------------------------------------------------------
// mvna_alu: shared bit-serial divide and square root unit
// One result bit per cycle. A divide gives floor(num / den) for a quotient
// that fits in 32 bits; a root gives floor(sqrt(num)) of a 64-bit value.
// ----------------------------------------------------------------------------
module mvna_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  mvna_pkg::alu_cmd_t  cmd,
	output mvna_pkg::alu_rsp_t  rsp
);

	logic        busy_q;
	logic        sqrt_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] num_q;
	logic [31:0] den_q;
	logic [31:0] res_q;
	logic        done_q;

	logic [65:0] trial;
	logic [65:0] rem_sh;
	logic        take;

	always_comb begin
		if (sqrt_q) begin
			rem_sh = {rem_q, num_q[63:62]};
			trial  = {32'd0, res_q, 2'b01};
		end else begin
			rem_sh = {1'b0, rem_q, num_q[63]};
			trial  = {34'd0, den_q};
		end
		take = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.is_sqrt ? 6'd31 : 6'd63;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.is_sqrt;
			num_q  <= cmd.num;
			den_q  <= cmd.den;
			rem_q  <= '0;
			res_q  <= '0;
		end else if (busy_q) begin
			rem_q <= take ? 64'(rem_sh - trial) : rem_sh[63:0];
			res_q <= {res_q[30:0], take};
			num_q <= sqrt_q ? {num_q[61:0], 2'b00} : {num_q[62:0], 1'b0};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// ----- rtl/mvna_seq.sv -----
// ----------------------------------------------------------------------------
// mvna_seq: operation sequencer with the vertex store
// Steps each add through store reads, the cross product, scaling, one root and three
// divides on the shared unit, and three read-modify-writes; a read only reads the store.
// ----------------------------------------------------------------------------
module mvna_seq #(
	parameter int unsigned VERTEX_COUNT = mvna_pkg::VertexCountDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rev_winding,
	input  logic                 in_go,
	input  mvna_pkg::in_beat_t   in_beat,
	output logic                 busy,
	output logic                 res_valid,
	output mvna_pkg::out_beat_t  res_beat,
	output mvna_pkg::alu_cmd_t   alu_cmd,
	input  mvna_pkg::alu_rsp_t   alu_rsp
);

	localparam int unsigned AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int unsigned CW = mvna_pkg::CoordW;
	localparam int unsigned NW = mvna_pkg::CompW;

	typedef enum logic [4:0] {
		S_IDLE, S_RD_P, S_RD_Q, S_RD_R, S_WAIT, S_EDGE, S_MUL, S_CROSS,
		S_MAG, S_SHIFT, S_SQ, S_SUM, S_ROOT, S_DIV, S_ACC_RD, S_ACC_WAIT,
		S_ACC_WR, S_READ_WAIT
	} state_t;

	state_t state_q;

	logic [3*CW-1:0]   coord_mem [VERTEX_COUNT];
	logic [3*NW:0]     norm_mem  [VERTEX_COUNT];
	logic [3*CW-1:0]   coord_rd_q;
	logic [3*NW:0]     norm_rd_q;
	logic [AW-1:0]     caddr;
	logic [AW-1:0]     naddr;

	logic [AW-1:0]     ia_q, ib_q, ic_q;
	logic              ok_a, ok_b, ok_c;
	logic signed [CW:0]   e1_q [3];
	logic signed [CW:0]   e2_q [3];
	logic signed [CW-1:0] p_q [3];
	logic signed [CW-1:0] q_q [3];
	logic signed [2*CW+2:0] prod_q [6];
	logic [1:0]        k_q;
	logic [2:0]        cnt_q;
	logic [34:0]       mag_q [3];
	logic              neg_q [3];
	logic [63:0]       sum_q;
	logic [63:0]       sq_q;
	logic [31:0]       len_q;
	logic [14:0]       unit_q [3];
	logic              alu_started_q;
	logic              read_q;

	logic [34:0]       max_m;
	logic [5:0]        lz;
	logic [48:0]       div_num;
	logic signed [NW+1:0] acc_s [3];
	logic [3*NW:0]     acc_word;

	// Leading-one position of the largest magnitude sets the common shift.
	always_comb begin
		max_m = mag_q[0];
		if (mag_q[1] > max_m) max_m = mag_q[1];
		if (mag_q[2] > max_m) max_m = mag_q[2];
		lz = 6'd0;
		for (int i = 0; i < 35; i++) begin
			if (max_m[i]) lz = 6'(i);
		end
	end

	assign div_num = {mag_q[k_q][31:0], 14'd0} + 49'(len_q[31:1]);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [NW-1:0] old_c;
			old_c = norm_rd_q[NW*(3-i) -: NW];
			acc_s[i] = (NW+2)'(old_c) + (neg_q[i] ? -(NW+2)'(unit_q[i])
				: (NW+2)'(unit_q[i]));
		end
		acc_word[0] = norm_rd_q[0];
		for (int i = 0; i < 3; i++) begin
			if (acc_s[i] > (NW+2)'(524287)) begin
				acc_word[NW*(3-i) -: NW] = NW'(524287);
				acc_word[0] = 1'b1;
			end else if (acc_s[i] < -(NW+2)'(524288)) begin
				acc_word[NW*(3-i) -: NW] = NW'(20'h80000);
				acc_word[0] = 1'b1;
			end else begin
				acc_word[NW*(3-i) -: NW] = acc_s[i][NW-1:0];
			end
		end
	end

	always_comb begin
		unique case (k_q)
			2'd0:    naddr = ia_q;
			2'd1:    naddr = ib_q;
			default: naddr = ic_q;
		endcase
		unique case (state_q)
			S_RD_P:  caddr = rev_winding ? ic_q : ia_q;
			S_RD_Q:  caddr = ib_q;
			default: caddr = rev_winding ? ia_q : ic_q;
		endcase
	end

	assign ok_a = 32'(in_beat.index_a) < VERTEX_COUNT;
	assign ok_b = 32'(in_beat.index_b) < VERTEX_COUNT;
	assign ok_c = 32'(in_beat.index_c) < VERTEX_COUNT;

	always_ff @(posedge clk) begin
		coord_rd_q <= coord_mem[caddr];
		norm_rd_q  <= norm_mem[naddr];
		if (in_go && ok_a && (in_beat.op == mvna_pkg::OP_LOAD)) begin
			coord_mem[AW'(in_beat.index_a)] <= {in_beat.coord_x, in_beat.coord_y,
				in_beat.coord_z};
		end
		if (in_go && ok_a && ((in_beat.op == mvna_pkg::OP_LOAD)
				|| (in_beat.op == mvna_pkg::OP_CLEAR))) begin
			norm_mem[AW'(in_beat.index_a)] <= '0;
		end else if (state_q == S_ACC_WR) begin
			norm_mem[naddr] <= acc_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_valid <= 1'b0;
			alu_started_q <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			alu_started_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_go) begin
						ia_q <= AW'(in_beat.index_a);
						ib_q <= AW'(in_beat.index_b);
						ic_q <= AW'(in_beat.index_c);
						k_q  <= 2'd0;
						if (in_beat.op == mvna_pkg::OP_ADD && ok_a && ok_b && ok_c)
							state_q <= S_RD_P;
						else if (in_beat.op == mvna_pkg::OP_READ) begin
							if (ok_a) state_q <= S_READ_WAIT;
							else begin
								res_beat  <= '0;
								res_valid <= 1'b1;
							end
						end
					end
				end
				S_READ_WAIT: begin
					state_q <= S_ACC_WAIT;
				end
				S_RD_P: state_q <= S_RD_Q;
				S_RD_Q: begin
					for (int i = 0; i < 3; i++)
						p_q[i] <= coord_rd_q[CW*(3-i)-1 -: CW];
					state_q <= S_RD_R;
				end
				S_RD_R: begin
					for (int i = 0; i < 3; i++)
						q_q[i] <= coord_rd_q[CW*(3-i)-1 -: CW];
					state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_EDGE;
				S_EDGE: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= (CW+1)'(q_q[i]) - (CW+1)'(p_q[i]);
						e2_q[i] <= (CW+1)'($signed(coord_rd_q[CW*(3-i)-1 -: CW]))
							- (CW+1)'(p_q[i]);
					end
					cnt_q   <= 3'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					// Six 17 x 17 products, two per cycle.
					unique case (cnt_q)
						3'd0: begin
							prod_q[0] <= (2*CW+3)'(e1_q[1] * e2_q[2]);
							prod_q[1] <= (2*CW+3)'(e1_q[2] * e2_q[1]);
						end
						3'd1: begin
							prod_q[2] <= (2*CW+3)'(e1_q[2] * e2_q[0]);
							prod_q[3] <= (2*CW+3)'(e1_q[0] * e2_q[2]);
						end
						default: begin
							prod_q[4] <= (2*CW+3)'(e1_q[0] * e2_q[1]);
							prod_q[5] <= (2*CW+3)'(e1_q[1] * e2_q[0]);
						end
					endcase
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd2) state_q <= S_CROSS;
				end
				S_CROSS: begin
					for (int i = 0; i < 3; i++) begin
						logic signed [2*CW+3:0] cv;
						cv = (2*CW+4)'(prod_q[2*i+1]) - (2*CW+4)'(prod_q[2*i]);
						neg_q[i] <= cv[2*CW+3];
						mag_q[i] <= 35'(cv[2*CW+3] ? -cv : cv);
					end
					state_q <= S_MAG;
				end
				S_MAG: begin
					if (max_m == '0) state_q <= S_IDLE;
					else state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					for (int i = 0; i < 3; i++) begin
						if (lz > 6'd30) mag_q[i] <= mag_q[i] >> (lz - 6'd30);
						else mag_q[i] <= mag_q[i] << (6'd30 - lz);
					end
					sum_q   <= '0;
					k_q     <= 2'd0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					sq_q    <= 64'(mag_q[k_q][31:0]) * 64'(mag_q[k_q][31:0]);
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q <= sum_q + sq_q;
					if (k_q == 2'd2) begin
						state_q <= S_ROOT;
						alu_started_q <= 1'b1;
						k_q <= 2'd0;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= S_SQ;
					end
				end
				S_ROOT: begin
					if (alu_rsp.done) begin
						len_q   <= alu_rsp.result;
						state_q <= S_DIV;
						alu_started_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (alu_rsp.done) begin
						unit_q[k_q] <= alu_rsp.result[14:0];
						if (k_q == 2'd2) begin
							k_q <= 2'd0;
							state_q <= S_ACC_RD;
						end else begin
							k_q <= k_q + 2'd1;
							alu_started_q <= 1'b1;
						end
					end
				end
				S_ACC_RD: state_q <= S_ACC_WAIT;
				S_ACC_WAIT: begin
					// A read beat passes through here and leaves with its result.
					if (read_q) begin
						res_beat  <= norm_rd_q;
						res_valid <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_ACC_WR;
					end
				end
				S_ACC_WR: begin
					if (k_q == 2'd2) state_q <= S_IDLE;
					else begin
						k_q <= k_q + 2'd1;
						state_q <= S_ACC_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A read beat goes through the accumulate wait state with the read flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) read_q <= 1'b0;
		else if (state_q == S_IDLE) read_q <= in_go && (in_beat.op == mvna_pkg::OP_READ);
	end

	assign busy = (state_q != S_IDLE);
	assign alu_cmd.start   = alu_started_q;
	assign alu_cmd.is_sqrt = (state_q == S_ROOT);
	assign alu_cmd.num     = (state_q == S_ROOT) ? sum_q : 64'(div_num);
	assign alu_cmd.den     = len_q;

endmodule

// ----- rtl/mvna_checker.sv -----
// ----------------------------------------------------------------------------
// mvna_checker: port-level checks of the vertex normal accumulator
// Watches the handshakes on the top level's ports and is bound to it.
// ----------------------------------------------------------------------------
module mvna_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input mvna_pkg::out_beat_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	a_no_take_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result waits");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall || !out_valid)
		else $error("unexpected result after a beat");

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_mvna_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
